@@ rtl/core/csvtok_pkg.sv @@
// package with shared types and constants for the csv row field tokenizer
`default_nettype none

package csvtok_pkg;

   // widths of the register and the fields
   localparam int COUNT_W = 13;
   localparam int INDEX_W = 12;
   localparam int BYTE_W  = 8;

   // default column limit
   localparam int DEF_MAX_COLUMNS = 4096;

   // characters the parser reacts to
   localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
   localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

   // token kinds on the result channel
   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_FIELD = 2'd1,
      KIND_ROW   = 2'd2,
      KIND_ERROR = 2'd3
   } token_kind_type;

   // one result token
   typedef struct packed {
      token_kind_type       kind;
      logic [BYTE_W-1:0]    data;
      logic [INDEX_W-1:0]   index;
   } token_type;

endpackage

`default_nettype wire

@@ rtl/core/csv_row_field_tokenizer.sv @@
// csv row field tokenizer: byte parser with a small token buffer on the output
// latency: the first token of a byte is shown in the cycle after its transaction
// throughput: one byte per cycle while the receiver takes each token as it is shown; a byte giving
// several tokens holds the input: a new byte enters as the last buffered token leaves
// reset (synchronous, active high) clears the parser state and the token buffer
// and sets column_count to 1; no clearing pass is needed
`default_nettype none

module csv_row_field_tokenizer #(
   parameter int MAX_COLUMNS = csvtok_pkg::DEF_MAX_COLUMNS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [csvtok_pkg::COUNT_W-1:0]   csr_wr_data,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [csvtok_pkg::BYTE_W-1:0]    req_in_byte,
   input  wire logic                             req_start_of_file,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [1:0]                            rsp_token_kind,
   output logic [csvtok_pkg::BYTE_W-1:0]         rsp_data_byte,
   output logic [csvtok_pkg::INDEX_W-1:0]        rsp_column,
   output logic                                  rsp_last
);
   import csvtok_pkg::*;

   localparam logic [COUNT_W-1:0] MaxCol = COUNT_W'(MAX_COLUMNS);

   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_PLAIN  = 2'd1,
      MODE_QUOTED = 2'd2,
      MODE_SKIP   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_COMMA,
      ACT_EOL,
      ACT_ERROR,
      ACT_ROW
   } action_type;

   // parser state
   logic [COUNT_W-1:0] column_count_ff;
   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] field_cnt_ff, field_cnt_in;
   logic               bs_pend_ff, bs_pend_in;
   logic               qt_pend_ff, qt_pend_in;
   logic               cr_seen_ff, cr_seen_in;
   logic               qt_tail_ff, qt_tail_in;
   logic               halted_ff, halted_in;

   // token buffer
   token_type          tok_ff [3];
   token_type          tok_in [3];
   logic [1:0]         tok_cnt_ff, tok_cnt_in;
   logic [1:0]         rd_ptr_ff;

   logic [COUNT_W-1:0] limit;
   logic               req_fire;
   logic               rsp_fire;
   logic               rsp_done;
   token_type          cur_tok;

   assign limit = (column_count_ff > MaxCol) ? MaxCol : column_count_ff;

   // output side
   assign cur_tok         = tok_ff[rd_ptr_ff];
   assign rsp_valid       = (tok_cnt_ff != 2'd0);
   assign rsp_token_kind  = cur_tok.kind;
   assign rsp_data_byte   = cur_tok.data;
   assign rsp_column      = cur_tok.index;
   assign rsp_last        = (rd_ptr_ff == tok_cnt_ff - 2'd1);
   assign rsp_fire        = rsp_valid && rsp_ready;
   assign rsp_done        = rsp_fire && rsp_last;
   assign req_ready       = !rsp_valid || rsp_done;
   assign req_fire        = req_valid && req_ready;

   // parse one byte: next state and its tokens
   always_comb begin
      logic [BYTE_W-1:0]  b;
      logic               eol;
      logic               run;
      logic               run_plain;
      logic               run_esc;
      logic               run_fresh;
      action_type         act;
      logic [BYTE_W-1:0]  dat [2];
      logic [1:0]         nd;
      logic [1:0]         n;
      logic [COUNT_W-1:0] fc_next;

      b         = req_in_byte;
      eol       = (b == CH_CR) || (b == CH_LF);
      run       = 1'b1;
      run_plain = 1'b0;
      run_esc   = 1'b0;
      run_fresh = 1'b0;
      act       = ACT_NONE;
      dat[0]    = '0;
      dat[1]    = '0;
      nd        = 2'd0;
      n         = 2'd0;
      fc_next   = '0;

      mode_in      = mode_ff;
      field_cnt_in = field_cnt_ff;
      bs_pend_in   = bs_pend_ff;
      qt_pend_in   = qt_pend_ff;
      cr_seen_in   = cr_seen_ff;
      qt_tail_in   = qt_tail_ff;
      halted_in    = halted_ff;
      for (int i = 0; i < 3; i++) begin
         tok_in[i] = '{kind: KIND_DATA, data: '0, index: '0};
      end

      // start of file clears everything but the register
      if (req_start_of_file) begin
         mode_in      = MODE_START;
         field_cnt_in = '0;
         bs_pend_in   = 1'b0;
         qt_pend_in   = 1'b0;
         qt_tail_in   = 1'b0;
         cr_seen_in   = 1'b0;
         halted_in    = 1'b0;
      end

      if (halted_in) begin
         run = 1'b0;
      end else if (cr_seen_in) begin
         // lf after cr is swallowed
         cr_seen_in = 1'b0;
         if (b == CH_LF) begin
            run = 1'b0;
         end
      end

      if (run) begin
         if (b == CH_CR) begin
            cr_seen_in = 1'b1;
         end
         if (mode_in == MODE_START && field_cnt_in >= limit) begin
            mode_in = MODE_SKIP;
         end

         case (mode_in)
            MODE_START: begin
               if (eol) begin
                  act = ACT_ERROR;
               end else if (b == CH_QUOTE) begin
                  mode_in = MODE_QUOTED;
               end else begin
                  mode_in   = MODE_PLAIN;
                  run_plain = 1'b1;
               end
            end
            MODE_PLAIN: begin
               if (!eol) begin
                  run_plain = 1'b1;
               end else if (bs_pend_in) begin
                  // trailing backslash is kept as data
                  bs_pend_in = 1'b0;
                  dat[nd[0]] = CH_BSLASH;
                  nd         = nd + 2'd1;
                  act        = ACT_EOL;
               end else if (qt_pend_in) begin
                  act = ACT_ERROR;
               end else begin
                  act = ACT_EOL;
               end
            end
            MODE_QUOTED: begin
               if (eol) begin
                  if (bs_pend_in) begin
                     act = ACT_ERROR;
                  end else if (qt_pend_in) begin
                     act = ACT_EOL;
                  end else if (qt_tail_in) begin
                     act = ACT_ERROR;
                  end else begin
                     act = ACT_EOL;
                  end
               end else if (bs_pend_in) begin
                  bs_pend_in = 1'b0;
                  qt_tail_in = 1'b0;
                  run_esc    = 1'b1;
               end else if (qt_pend_in) begin
                  // held quote: closes at a comma, else it is data
                  qt_pend_in = 1'b0;
                  if (b == CH_COMMA) begin
                     act = ACT_COMMA;
                  end else begin
                     dat[nd[0]] = CH_QUOTE;
                     nd         = nd + 2'd1;
                     run_fresh  = 1'b1;
                  end
               end else begin
                  run_fresh = 1'b1;
               end
            end
            default: begin
               if (eol) begin
                  act = ACT_ROW;
               end
            end
         endcase

         // unquoted field byte
         if (run_plain) begin
            if (bs_pend_in) begin
               bs_pend_in = 1'b0;
               qt_pend_in = 1'b0;
               run_esc    = 1'b1;
            end else if (b == CH_COMMA) begin
               act = ACT_COMMA;
            end else if (b == CH_BSLASH) begin
               bs_pend_in = 1'b1;
               qt_pend_in = 1'b0;
            end else begin
               dat[nd[0]] = b;
               nd         = nd + 2'd1;
               qt_pend_in = (b == CH_QUOTE);
            end
         end

         // quoted field byte with nothing pending
         if (run_fresh) begin
            qt_tail_in = 1'b0;
            if (b == CH_QUOTE) begin
               qt_pend_in = 1'b1;
            end else if (b == CH_BSLASH) begin
               bs_pend_in = 1'b1;
            end else begin
               dat[nd[0]] = b;
               nd         = nd + 2'd1;
               qt_tail_in = 1'b1;
            end
         end

         // escape decode; unknown escapes keep the backslash
         if (run_esc) begin
            if (b == CH_R) begin
               dat[nd[0]] = CH_CR;
               nd         = nd + 2'd1;
            end else if (b == CH_N) begin
               dat[nd[0]] = CH_LF;
               nd         = nd + 2'd1;
            end else if (b == CH_BSLASH || b == CH_QUOTE) begin
               dat[nd[0]] = b;
               nd         = nd + 2'd1;
            end else begin
               dat[0] = CH_BSLASH;
               dat[1] = b;
               nd     = 2'd2;
            end
         end

         // data tokens first
         if (nd != 2'd0) begin
            tok_in[n] = '{kind: KIND_DATA, data: dat[0], index: field_cnt_in[INDEX_W-1:0]};
            n = n + 2'd1;
         end
         if (nd == 2'd2) begin
            tok_in[n] = '{kind: KIND_DATA, data: dat[1], index: field_cnt_in[INDEX_W-1:0]};
            n = n + 2'd1;
         end

         // then the closing action
         fc_next = field_cnt_in + COUNT_W'(1);
         case (act)
            ACT_COMMA: begin
               tok_in[n] = '{kind: KIND_FIELD, data: '0, index: field_cnt_in[INDEX_W-1:0]};
               n = n + 2'd1;
               field_cnt_in = fc_next;
               mode_in      = (fc_next >= limit) ? MODE_SKIP : MODE_START;
               bs_pend_in   = 1'b0;
               qt_pend_in   = 1'b0;
               qt_tail_in   = 1'b0;
            end
            ACT_EOL: begin
               tok_in[n] = '{kind: KIND_FIELD, data: '0, index: field_cnt_in[INDEX_W-1:0]};
               n = n + 2'd1;
               if (fc_next >= limit) begin
                  tok_in[n] = '{kind: KIND_ROW, data: '0, index: '0};
                  n = n + 2'd1;
                  mode_in      = MODE_START;
                  field_cnt_in = '0;
                  bs_pend_in   = 1'b0;
                  qt_pend_in   = 1'b0;
                  qt_tail_in   = 1'b0;
               end else begin
                  // row ended with fields missing
                  tok_in[n] = '{kind: KIND_ERROR, data: '0, index: fc_next[INDEX_W-1:0]};
                  n = n + 2'd1;
                  field_cnt_in = fc_next;
                  halted_in    = 1'b1;
               end
            end
            ACT_ERROR: begin
               tok_in[n] = '{kind: KIND_ERROR, data: '0, index: field_cnt_in[INDEX_W-1:0]};
               n = n + 2'd1;
               halted_in = 1'b1;
            end
            ACT_ROW: begin
               tok_in[n] = '{kind: KIND_ROW, data: '0, index: '0};
               n = n + 2'd1;
               mode_in      = MODE_START;
               field_cnt_in = '0;
               bs_pend_in   = 1'b0;
               qt_pend_in   = 1'b0;
               qt_tail_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end

      tok_cnt_in = n;
   end

   // parser state and config register
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COUNT_W'(1);
         mode_ff         <= MODE_START;
         field_cnt_ff    <= '0;
         bs_pend_ff      <= 1'b0;
         qt_pend_ff      <= 1'b0;
         cr_seen_ff      <= 1'b0;
         qt_tail_ff      <= 1'b0;
         halted_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            column_count_ff <= csr_wr_data;
         end
         if (req_fire) begin
            mode_ff      <= mode_in;
            field_cnt_ff <= field_cnt_in;
            bs_pend_ff   <= bs_pend_in;
            qt_pend_ff   <= qt_pend_in;
            cr_seen_ff   <= cr_seen_in;
            qt_tail_ff   <= qt_tail_in;
            halted_ff    <= halted_in;
         end
      end
   end

   // token buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_cnt_ff <= 2'd0;
         rd_ptr_ff  <= 2'd0;
      end else if (req_fire) begin
         tok_cnt_ff <= tok_cnt_in;
         rd_ptr_ff  <= 2'd0;
      end else if (rsp_done) begin
         tok_cnt_ff <= 2'd0;
         rd_ptr_ff  <= 2'd0;
      end else if (rsp_fire) begin
         rd_ptr_ff <= rd_ptr_ff + 2'd1;
      end
   end

   // token buffer payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < 3; i++) begin
            tok_ff[i] <= tok_in[i];
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/csvtok_checker.sv @@
// port level checker for the csv row field tokenizer, bound to the top level
`default_nettype none

module csvtok_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [1:0]                       rsp_token_kind,
   input wire logic [csvtok_pkg::BYTE_W-1:0]    rsp_data_byte,
   input wire logic [csvtok_pkg::INDEX_W-1:0]   rsp_column,
   input wire logic                             rsp_last
);
   import csvtok_pkg::*;

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_data_byte) && $stable(rsp_column) && $stable(rsp_last)))
      else $error("result transaction changed while stalled");

   // no new byte while tokens of the previous one are still pending
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !(rsp_ready && rsp_last)) |-> !req_ready)
      else $error("input taken while tokens are pending");

   // only data tokens carry a byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind != KIND_DATA) |-> (rsp_data_byte == '0))
      else $error("non-data token with a nonzero byte");

   // a row end or error closes the tokens of its byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_token_kind == KIND_ROW || rsp_token_kind == KIND_ERROR)) |-> rsp_last)
      else $error("row end or error not last");

   // row end reports column zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == KIND_ROW) |-> (rsp_column == '0))
      else $error("row end with nonzero column");

endmodule

bind csv_row_field_tokenizer csvtok_checker u_csvtok_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_token_kind  (rsp_token_kind),
   .rsp_data_byte   (rsp_data_byte),
   .rsp_column      (rsp_column),
   .rsp_last        (rsp_last)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// self-checking testbench for the csv row field tokenizer
module tb_top;
   import csvtok_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 8;
   localparam int MAX_COLS      = DEF_MAX_COLUMNS;
   localparam int MAX_TOKENS    = 3;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [1:0] {
      PM_START  = 2'd0,
      PM_PLAIN  = 2'd1,
      PM_QUOTED = 2'd2,
      PM_SKIP   = 2'd3
   } parse_mode_type;

   typedef struct {
      token_kind_type       kind;
      logic [BYTE_W-1:0]    data;
      logic [INDEX_W-1:0]   index;
      logic                 last;
   } expected_token_type;

   // block ports
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]   csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_in_byte = '0;
   logic                 req_start_of_file = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_token_kind;
   logic [BYTE_W-1:0]    rsp_data_byte;
   logic [INDEX_W-1:0]   rsp_column;
   logic                 rsp_last;

   csv_row_field_tokenizer uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_start_of_file (req_start_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_column        (rsp_column),
      .rsp_last          (rsp_last)
   );

   // clock
   always #HALF_PERIOD clock = ~clock;

   // run limit
   int unsigned cycle_count = 0;
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------
   // parser prediction
   // ---------------------------------------------------------------
   logic [COUNT_W-1:0]   prs_columns = 13'd1;
   parse_mode_type       prs_mode = PM_START;
   logic [COUNT_W-1:0]   prs_col = '0;
   logic                 prs_escape = 1'b0;
   logic                 prs_quote = 1'b0;
   logic                 prs_cr_seen = 1'b0;
   logic                 prs_tail_ord = 1'b0;
   logic                 prs_halted = 1'b0;

   expected_token_type   byte_tokens[$];
   expected_token_type   expected_tokens[$];

   // effective column limit
   function automatic logic [COUNT_W-1:0] col_limit();
      return (prs_columns > MAX_COLS) ? COUNT_W'(MAX_COLS) : prs_columns;
   endfunction

   // one token of the current byte, at most three per byte
   function automatic void put_token(token_kind_type kind, logic [BYTE_W-1:0] data,
                                     logic [COUNT_W-1:0] col);
      expected_token_type tok;
      if (byte_tokens.size() >= MAX_TOKENS) return;
      tok.kind  = kind;
      tok.data  = (kind == KIND_DATA) ? data : '0;
      tok.index = col[INDEX_W-1:0];
      tok.last  = 1'b0;
      byte_tokens.push_back(tok);
   endfunction

   function automatic void emit_byte(logic [BYTE_W-1:0] data);
      put_token(KIND_DATA, data, prs_col);
   endfunction

   function automatic void clear_row();
      prs_mode     = PM_START;
      prs_col      = '0;
      prs_escape   = 1'b0;
      prs_quote    = 1'b0;
      prs_tail_ord = 1'b0;
   endfunction

   function automatic void flag_error();
      put_token(KIND_ERROR, '0, prs_col);
      prs_halted = 1'b1;
   endfunction

   // escaped byte: r, n, backslash and quote decode, anything else keeps the backslash
   function automatic void decode_escape(logic [BYTE_W-1:0] b);
      case (b)
         CH_R: emit_byte(CH_CR);
         CH_N: emit_byte(CH_LF);
         CH_BSLASH, CH_QUOTE: emit_byte(b);
         default: begin
            emit_byte(CH_BSLASH);
            emit_byte(b);
         end
      endcase
   endfunction

   // field closed by a comma
   function automatic void end_field_comma();
      put_token(KIND_FIELD, '0, prs_col);
      prs_col      = prs_col + 1'b1;
      prs_mode     = (prs_col >= col_limit()) ? PM_SKIP : PM_START;
      prs_escape   = 1'b0;
      prs_quote    = 1'b0;
      prs_tail_ord = 1'b0;
   endfunction

   // field closed by a line end: row end when complete, else missing field
   function automatic void end_field_line();
      put_token(KIND_FIELD, '0, prs_col);
      prs_col = prs_col + 1'b1;
      if (prs_col >= col_limit()) begin
         put_token(KIND_ROW, '0, '0);
         clear_row();
      end else begin
         flag_error();
      end
   endfunction

   // non line end byte of an unquoted field
   function automatic void take_plain(logic [BYTE_W-1:0] b);
      if (prs_escape) begin
         prs_escape = 1'b0;
         prs_quote  = 1'b0;
         decode_escape(b);
      end else if (b == CH_COMMA) begin
         end_field_comma();
      end else if (b == CH_BSLASH) begin
         prs_escape = 1'b1;
         prs_quote  = 1'b0;
      end else begin
         emit_byte(b);
         prs_quote = (b == CH_QUOTE);
      end
   endfunction

   // byte of a quoted field with nothing held back
   function automatic void take_quoted(logic [BYTE_W-1:0] b);
      prs_tail_ord = 1'b0;
      if (b == CH_QUOTE) begin
         prs_quote = 1'b1;
      end else if (b == CH_BSLASH) begin
         prs_escape = 1'b1;
      end else begin
         emit_byte(b);
         prs_tail_ord = 1'b1;
      end
   endfunction

   // expected tokens of one accepted byte, appended to the store
   function automatic int predict_byte(logic [BYTE_W-1:0] b, logic sof);
      logic eol;
      byte_tokens.delete();
      if (sof) begin
         clear_row();
         prs_cr_seen = 1'b0;
         prs_halted  = 1'b0;
      end
      if (prs_halted) return 0;
      // lf right after cr is swallowed
      if (prs_cr_seen) begin
         prs_cr_seen = 1'b0;
         if (b == CH_LF) return 0;
      end
      eol = (b == CH_CR) || (b == CH_LF);
      if (b == CH_CR) prs_cr_seen = 1'b1;
      if (prs_mode == PM_START && prs_col >= col_limit()) prs_mode = PM_SKIP;

      case (prs_mode)
         PM_START: begin
            if (eol) flag_error();
            else if (b == CH_QUOTE) prs_mode = PM_QUOTED;
            else begin
               prs_mode = PM_PLAIN;
               take_plain(b);
            end
         end
         PM_PLAIN: begin
            if (!eol) begin
               take_plain(b);
            end else if (prs_escape) begin
               prs_escape = 1'b0;
               emit_byte(CH_BSLASH);
               end_field_line();
            end else if (prs_quote) begin
               flag_error();
            end else begin
               end_field_line();
            end
         end
         PM_QUOTED: begin
            if (eol) begin
               if (prs_escape || (!prs_quote && prs_tail_ord)) flag_error();
               else end_field_line();
            end else if (prs_escape) begin
               prs_escape   = 1'b0;
               prs_tail_ord = 1'b0;
               decode_escape(b);
            end else if (prs_quote) begin
               prs_quote = 1'b0;
               if (b == CH_COMMA) end_field_comma();
               else begin
                  emit_byte(CH_QUOTE);
                  take_quoted(b);
               end
            end else begin
               take_quoted(b);
            end
         end
         default: begin
            if (eol) begin
               put_token(KIND_ROW, '0, '0);
               clear_row();
            end
         end
      endcase

      if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
      return byte_tokens.size();
   endfunction

   // ---------------------------------------------------------------
   // result channel: ready with random idling and long hold-offs
   // ---------------------------------------------------------------
   int recv_idle_pct = 38;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------
   // token checking on each result transaction
   // ---------------------------------------------------------------
   int error_count = 0;

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      expected_token_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tokens.size() == 0) begin
            error_count++;
            $display("%0t: unexpected token, expected none, actual kind %0d data %0h index %0d",
                     $time, rsp_token_kind, rsp_data_byte, rsp_column);
         end else begin
            want = expected_tokens.pop_front();
            check_field("token_kind", want.kind, rsp_token_kind);
            check_field("data_byte", want.data, rsp_data_byte);
            check_field("column", want.index, rsp_column);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // ---------------------------------------------------------------
   // input channel
   // ---------------------------------------------------------------
   int send_idle_pct = 38;
   int sent_items    = 0;

   // one byte transaction; returns at the accepting edge with valid still high
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic sof);
      @(negedge clock);
      // idle cycles at random before offering
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_start_of_file <= sof;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      void'(predict_byte(b, sof));
      sent_items++;
   endtask

   task automatic send_text(input string text, input logic sof_first);
      for (int i = 0; i < text.len(); i++) send_byte(text[i], sof_first && (i == 0));
   endtask

   // stop offering and wait for every expected token, then let the pipe settle
   task automatic drain_tokens();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // column count write, only with the block idle
   task automatic write_columns(input logic [COUNT_W-1:0] value);
      drain_tokens();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      prs_columns = value;
   endtask

   // ---------------------------------------------------------------
   // random row content
   // ---------------------------------------------------------------
   function automatic logic [BYTE_W-1:0] random_text_byte();
      case ($urandom_range(3))
         0, 1: return 8'h61 + 8'($urandom_range(25));
         2: return 8'($urandom_range(255));
         default: return 8'h30 + 8'($urandom_range(9));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] escape_pick();
      case ($urandom_range(4))
         0: return CH_R;
         1: return CH_N;
         2: return CH_BSLASH;
         3: return CH_QUOTE;
         default: return random_text_byte();
      endcase
   endfunction

   // one line of nfields fields, quoted or not, with random content and line end
   task automatic send_row(input int nfields, input logic sof);
      logic [BYTE_W-1:0] line[$];
      int len;
      int pick;
      bit quoted;
      for (int f = 0; f < nfields; f++) begin
         quoted = ($urandom_range(99) < 40);
         if (f > 0) line.push_back(CH_COMMA);
         if (quoted) line.push_back(CH_QUOTE);
         len = $urandom_range(0, 4);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(19);
            if (pick < 3) begin
               line.push_back(CH_BSLASH);
               line.push_back(escape_pick());
            end else if (pick == 3) begin
               line.push_back(quoted ? CH_COMMA : CH_QUOTE);
            end else if (pick == 4) begin
               line.push_back(CH_QUOTE);
            end else begin
               line.push_back(random_text_byte());
            end
         end
         // mostly closed quotes, sometimes a dangling backslash or no close
         if (quoted && $urandom_range(9) != 0) line.push_back(CH_QUOTE);
         else if ($urandom_range(19) == 0) line.push_back(CH_BSLASH);
      end
      case ($urandom_range(2))
         0: line.push_back(CH_LF);
         1: line.push_back(CH_CR);
         default: begin
            line.push_back(CH_CR);
            line.push_back(CH_LF);
         end
      endcase
      foreach (line[i]) send_byte(line[i], sof && (i == 0));
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // reset column count of one, quoted field with escaped cr, extra column skipped
   task automatic test_reset_count();
      send_text("\"\\r\"\n", 1'b0);
      send_text("p,q\n", 1'b0);
   endtask

   // quote closes, quote kept as data, escapes, trailing backslash, crlf
   task automatic test_quoted_fields();
      write_columns(13'd2);
      send_text("\"a\"b\",\\\\\\\015\n", 1'b1);
      send_text("\\q\\\",\"\\\"\"\n", 1'b0);
   endtask

   // line errors and the halt until start of file
   task automatic test_line_errors();
      write_columns(13'd2);
      // unclosed quoted field ending on an ordinary byte, then halted
      send_text("\"x\n", 1'b1);
      send_text("y", 1'b0);
      // lone backslash at the line end of a quoted field
      send_text("\"\\\015", 1'b1);
      // quoted field ending after an escape, then a missing field
      send_text("\"\\n\n", 1'b1);
      // line end right after the opening quote
      send_text("\"\015", 1'b1);
      // stray quote at the end of an unquoted field
      send_text("a\"\n", 1'b1);
      // trailing comma and empty line
      send_text(",\n", 1'b1);
      send_text("\n", 1'b1);
   endtask

   // new column count in the middle of a row applies from the next field
   task automatic test_count_change_mid_row();
      write_columns(13'd3);
      send_text("a,b", 1'b1);
      write_columns(13'd2);
      send_text(",c\n", 1'b0);
   endtask

   // zero columns and counts at and above the column limit
   task automatic test_column_extremes();
      write_columns(13'd0);
      send_text("a,\"b\n", 1'b1);
      write_columns(13'h1FFF);
      send_text("a\n", 1'b1);
      write_columns(13'd4096);
      send_text("b,c\n", 1'b1);
   endtask

   // receiver holds off while the sender keeps offering, then a full pause
   task automatic test_hold_and_pause();
      write_columns(13'd3);
      send_idle_pct = 0;
      hold_requests++;
      repeat (3) send_row(3, prs_halted);
      send_idle_pct = 38;
      drain_tokens();
      send_row(3, prs_halted);
   endtask

   // mostly well formed rows, some broken rows and raw noise
   task automatic test_random_rows(input logic [COUNT_W-1:0] columns, input int items);
      int goal;
      int base;
      write_columns(columns);
      goal = sent_items + items;
      base = (columns == 0) ? 1 : int'(columns);
      while (sent_items < goal) begin
         case ($urandom_range(9))
            0: begin
               repeat ($urandom_range(1, 6))
                  send_byte(8'($urandom_range(255)),
                            prs_halted ? ($urandom_range(1) == 0) : ($urandom_range(19) == 0));
            end
            1: begin
               send_row(($urandom_range(1) == 0) ? base + 1 : ((base > 1) ? base - 1 : base),
                        prs_halted || ($urandom_range(29) == 0));
            end
            default: begin
               send_row(base, prs_halted || ($urandom_range(29) == 0));
            end
         endcase
      end
   endtask

   // main sequence
   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_reset_count();
      test_quoted_fields();
      test_line_errors();
      test_count_change_mid_row();
      test_column_extremes();
      test_hold_and_pause();

      test_random_rows(13'd2, 15);
      test_random_rows(13'd1, 10);
      // stretch with no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_rows(13'd3, 40);
      send_idle_pct = 38;
      recv_idle_pct = 38;
      test_random_rows(13'd4, 10);
      test_random_rows(13'd0, 5);
      test_random_rows(13'd5, 10);

      drain_tokens();
      if (error_count == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

endmodule
